// ----- rtl/core/ird_pkg.sv -----
// Shared types and constants for the IR relative interval decoder.
package ird_pkg;

  localparam int CODE_BITS  = 31;
  localparam int CODE_SPAN  = 32;
  localparam int IVL_W      = 16;
  localparam int COUNT_W    = 8;
  localparam int SKIP_W     = 4;
  localparam int PCT_W      = 7;
  localparam int TOL_W      = 10;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  // floor(p / 100) == floor(floor(p / 4) * RECIP_25 / 2**RECIP_SHIFT) for 16-bit p
  localparam logic [14:0] RECIP_25    = 15'd20972;
  localparam int          RECIP_SHIFT = 19;

  localparam logic KIND_INTERVAL = 1'b0;
  localparam logic KIND_TIMEOUT  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_PCT    = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IVL_W-1:0] interval;
  } item_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [COUNT_W-1:0]   capture_total;
  } result_t;

  // Interval with its precomputed tolerance, passed to the frame stage
  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [IVL_W-1:0] interval;
    logic [TOL_W-1:0] tol;
  } win_t;

endpackage

// ----- rtl/core/ird_window.sv -----
// Two-stage tolerance pipeline: percent scaling, then divide by 100.
module ird_window
  import ird_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  input  logic [PCT_W-1:0] tolerance_percent,
  output win_t             win,
  input  logic             win_ready
);

  logic             a_valid;
  logic             a_kind;
  logic [IVL_W-1:0] a_interval;
  logic [IVL_W-1:0] a_prod;
  logic             a_ready;

  logic [IVL_W+PCT_W-1:0]    prod_full;
  logic [28:0]               recip_prod;
  logic [TOL_W-1:0]          tol_next;

  assign prod_full  = item.interval * tolerance_percent;
  assign recip_prod = a_prod[IVL_W-1:2] * RECIP_25;
  assign tol_next   = recip_prod[RECIP_SHIFT+TOL_W-1:RECIP_SHIFT];

  assign a_ready    = !win.valid || win_ready;
  assign item_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_ready) begin
      a_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      a_kind     <= item.kind;
      a_interval <= item.interval;
      a_prod     <= prod_full[IVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win.valid <= 1'b0;
    end else if (a_ready) begin
      win.valid <= a_valid;
    end
    if (a_ready && a_valid) begin
      win.kind     <= a_kind;
      win.interval <= a_interval;
      win.tol      <= tol_next;
    end
  end

endmodule

// ----- rtl/core/ird_frame.sv -----
// Frame state: position count, reference window, code shift and result register.
module ird_frame
  import ird_pkg::*;
#(
  parameter int MAX_CAPTURES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  win_t              win,
  output logic              win_ready,
  input  logic [SKIP_W-1:0] skip_count,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result
);

  logic [COUNT_W-1:0]   capture_count;
  logic [IVL_W-1:0]     low_bound;
  logic [IVL_W-1:0]     high_bound;
  logic [CODE_BITS-1:0] code_shift;

  logic                 take;
  logic                 is_timeout;
  logic                 has_room;
  logic [COUNT_W:0]     span_end;
  logic                 at_ref;
  logic                 in_span;
  logic                 outside;
  logic [IVL_W-1:0]     low_next;
  logic [IVL_W-1:0]     high_next;

  assign is_timeout = (win.kind == KIND_TIMEOUT);
  assign win_ready  = !is_timeout || !result_valid || !result_stall;
  assign take       = win.valid && win_ready;

  assign has_room  = capture_count < COUNT_W'(MAX_CAPTURES);
  assign span_end  = {5'd0, skip_count} + (COUNT_W+1)'(CODE_SPAN);
  assign at_ref    = capture_count == {4'd0, skip_count};
  assign in_span   = (capture_count > {4'd0, skip_count}) && ({1'b0, capture_count} < span_end);
  assign outside   = (win.interval < low_bound) || (win.interval > high_bound);
  assign low_next  = win.interval - {6'd0, win.tol};
  assign high_next = win.interval + {6'd0, win.tol};

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_count <= '0;
      low_bound     <= '0;
      high_bound    <= '0;
      code_shift    <= '0;
    end else if (take) begin
      if (is_timeout) begin
        capture_count <= '0;
        low_bound     <= '0;
        high_bound    <= '0;
        code_shift    <= '0;
      end else if (has_room) begin
        capture_count <= capture_count + COUNT_W'(1);
        if (at_ref || in_span) begin
          low_bound  <= low_next;
          high_bound <= high_next;
        end
        if (in_span) begin
          code_shift <= {code_shift[CODE_BITS-2:0], outside};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && is_timeout) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (take && is_timeout) begin
      result.code          <= code_shift;
      result.capture_total <= capture_count;
    end
  end

endmodule

// ----- rtl/core/ir_relative_interval_decoder_core.sv -----
// Top level of the IR relative interval decoder: config registers and pipeline.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+----------------------------
//  item      | in        | item_valid / item_stall   | item_t   {kind, interval}
//  result    | out       | result_valid / result_stall | result_t {code, capture_total}
//  cfg       | in        | cfg_we (no wait)          | cfg_index, cfg_data
//
//  One transaction per cycle sustained while no timeout waits on a stalled
//  result; an interval's effect lands after the scale multiply register,
//  then the divide-by-100 multiply register, then the frame update.
//  A timeout's result reaches the result register through the same pipeline registers.
//  Reset (rst, synchronous) empties the pipeline, clears frame state and
//  restores skip_count = 2, tolerance_percent = 25.
//  A stalled result blocks only timeouts at the frame stage; intervals keep
//  flowing, and the pipeline holds when a timeout is waiting.
module ir_relative_interval_decoder_core
  import ird_pkg::*;
#(
  parameter int MAX_CAPTURES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // item channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SKIP_W-1:0] skip_count;
  logic [PCT_W-1:0]  tolerance_percent;
  logic              item_ready;
  win_t              win;
  logic              win_ready;

  // Config registers; the user must write them only while no transaction is in flight; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count        <= SKIP_W'(2);
      tolerance_percent <= PCT_W'(25);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SKIP_COUNT: skip_count        <= cfg_data[SKIP_W-1:0];
        REG_TOL_PCT:    tolerance_percent <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  assign item_stall = !item_ready;

  // Tolerance per interval: (interval * pct mod 2^16) / 100
  ird_window u_window (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .item              (item),
    .tolerance_percent (tolerance_percent),
    .win               (win),
    .win_ready         (win_ready)
  );

  // Window compare, code shift, capture count and result register
  ird_frame #(
    .MAX_CAPTURES (MAX_CAPTURES)
  ) u_frame (
    .clk          (clk),
    .rst          (rst),
    .win          (win),
    .win_ready    (win_ready),
    .skip_count   (skip_count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
